// ===== rtl/fopo_pkg.sv =====
// Shared types and constants for the frame orientation and point-operation block.
// Used by the controller, the datapath and the top level; depends on nothing.
package fopo_pkg;

	// Frame store geometry.
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int PTR_W       = ADDR_W + 1;
	localparam int POS_W       = $clog2(MAX_WIDTH);
	localparam int DIM_W       = 9;
	localparam int PIX_W       = 8;
	localparam int IDX_W       = 3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [IDX_W-1:0] REG_WIDTH      = 3'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT     = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_LEVEL  = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP       = 3'd4;

	// Mode codes.
	localparam logic [2:0] MODE_NEGATIVE = 3'd0;
	localparam logic [2:0] MODE_MIRROR   = 3'd1;
	localparam logic [2:0] MODE_ROT_R    = 3'd2;
	localparam logic [2:0] MODE_ROT_L    = 3'd3;
	localparam logic [2:0] MODE_DARKEN   = 3'd4;
	localparam logic [2:0] MODE_BRIGHTEN = 3'd5;

	// Input command codes.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	// Reset values of the registers.
	localparam logic [DIM_W-1:0] WIDTH_RST  = 9'd256;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd256;
	localparam logic [PIX_W-1:0] MAX_RST    = 8'd255;
	localparam logic [PIX_W-1:0] STEP_RST   = 8'd80;
	localparam logic [PTR_W-1:0] AREA_RST   = PTR_W'(STORE_DEPTH);

	// Configuration as seen by the datapath, with dimensions already clamped.
	typedef struct packed {
		logic [2:0]       mode;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [PIX_W-1:0] max_level;
		logic [PIX_W-1:0] step_amount;
		logic [PTR_W-1:0] area;
	} fopo_cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic load_write;
		logic pos_step;
		logic mul_step;
		logic read_step;
		logic out_load;
	} fopo_cmd_t;

endpackage

// ===== rtl/frame_orientation_point_op.sv =====
// Top level of the frame orientation and point-operation block: configuration registers
// and the controller and datapath instances. Depends on fopo_pkg, fopo_ctrl, fopo_datapath.
//
//   Channel  Handshake                    Payload
//   input    in_valid / in_stall          command, pixel_in
//   output   out_valid / out_stall        pixel_out, last_of_frame
//   config   cfg_write_en                 cfg_index, cfg_data
//
// A load item is taken every cycle while no fetch is in progress; its store write happens
// in the cycle after acceptance. A fetch item takes four steps: output position, address
// multiply, registered store read, and point operation into the output register. The input
// stalls until that last step has loaded the result, and a stalled result holds the fetch
// sequence in its last step.
// Reset clears config, control state, pointers, counters; the frame store is not cleared.
module frame_orientation_point_op import fopo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             command,
	input  logic [PIX_W-1:0] pixel_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PIX_W-1:0] pixel_out,
	output logic             last_of_frame,
	input  logic             cfg_write_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	logic [2:0]       mode_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic [PIX_W-1:0] max_level_q, step_q;
	logic [PTR_W-1:0] area_q;
	logic [DIM_W-1:0] w_clamp, h_clamp;
	fopo_cfg_t        cfg;
	fopo_cmd_t        cmd;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NEGATIVE;
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			max_level_q <= MAX_RST;
			step_q      <= STEP_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_MODE:      mode_q      <= cfg_data[2:0];
				REG_WIDTH:     width_q     <= cfg_data;
				REG_HEIGHT:    height_q    <= cfg_data;
				REG_MAX_LEVEL: max_level_q <= cfg_data[PIX_W-1:0];
				REG_STEP:      step_q      <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Dimensions clamped to the store: zero acts as one, oversize as the maximum.
	always_comb begin
		if (width_q == '0) begin
			w_clamp = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_WIDTH)) begin
			w_clamp = DIM_W'(MAX_WIDTH);
		end else begin
			w_clamp = width_q;
		end
		if (height_q == '0) begin
			h_clamp = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			h_clamp = DIM_W'(MAX_HEIGHT);
		end else begin
			h_clamp = height_q;
		end
	end

	// Frame area, registered; a load is checked against it in the cycle after acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= AREA_RST;
		end else begin
			area_q <= {{(PTR_W-DIM_W){1'b0}}, w_clamp} * {{(PTR_W-DIM_W){1'b0}}, h_clamp};
		end
	end

	assign cfg.mode        = mode_q;
	assign cfg.width       = w_clamp;
	assign cfg.height      = h_clamp;
	assign cfg.max_level   = max_level_q;
	assign cfg.step_amount = step_q;
	assign cfg.area        = area_q;

	fopo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	fopo_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg),
		.pixel_in      (pixel_in),
		.pixel_out     (pixel_out),
		.last_of_frame (last_of_frame)
	);

endmodule

// ===== rtl/fopo_ctrl.sv =====
// Controller state machine: input and output handshakes and the fetch sequence.
// Depends on fopo_pkg; drives the datapath through fopo_cmd_t.
module fopo_ctrl import fopo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      command,
	output logic      out_valid,
	input  logic      out_stall,
	output fopo_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOAD = 6'b000010,
		S_POS  = 6'b000100,
		S_MUL  = 6'b001000,
		S_READ = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	// Loads stream one per cycle; a fetch holds the input until its result is registered.
	assign in_stall  = !((state_q == S_IDLE) || (state_q == S_LOAD));
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_nxt          = state_q;
		cmd                = '0;
		cmd.capture        = accept;
		unique case (state_q)
			S_IDLE, S_LOAD: begin
				cmd.load_write = (state_q == S_LOAD);
				if (accept) begin
					state_nxt = (command == CMD_LOAD) ? S_LOAD : S_POS;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_POS: begin
				cmd.pos_step = 1'b1;
				state_nxt    = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				state_nxt    = S_READ;
			end
			S_READ: begin
				cmd.read_step = 1'b1;
				state_nxt     = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output valid: set when a result is registered, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/fopo_datapath.sv =====
// Datapath: frame store, load pointer, output counters, address and point operation.
// Depends on fopo_pkg; steered by fopo_cmd_t from the controller.
module fopo_datapath import fopo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  fopo_cmd_t        cmd,
	input  fopo_cfg_t        cfg,
	input  logic [PIX_W-1:0] pixel_in,
	output logic [PIX_W-1:0] pixel_out,
	output logic             last_of_frame
);

	logic [PIX_W-1:0]  mem [0:STORE_DEPTH-1];
	logic [PTR_W-1:0]  lp_q;
	logic [PIX_W-1:0]  pix_q;
	logic [POS_W-1:0]  row_q, col_q;
	logic [POS_W-1:0]  sr_s1, sc_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] prod_s2;
	logic [POS_W-1:0]  sc_s2;
	logic [PIX_W-1:0]  rdata_s3;
	logic [PIX_W-1:0]  pixel_out_q;
	logic              last_q;

	logic              rotated;
	logic [DIM_W-1:0]  orows, ocols;
	logic [POS_W-1:0]  row_e, col_e;
	logic [POS_W-1:0]  w_m1, h_m1;
	logic [POS_W-1:0]  sr, sc;
	logic              last;
	logic [DIM_W-1:0]  col_inc;
	logic              load_ok;
	logic [ADDR_W-1:0] rd_addr;
	logic [PIX_W:0]    bright_sum;
	logic [PIX_W-1:0]  value;

	// Output frame shape and counters wrapped back to zero if outside it.
	always_comb begin
		rotated = (cfg.mode == MODE_ROT_R) || (cfg.mode == MODE_ROT_L);
		orows   = rotated ? cfg.width : cfg.height;
		ocols   = rotated ? cfg.height : cfg.width;
		if (({1'b0, row_q} >= orows) || ({1'b0, col_q} >= ocols)) begin
			row_e = '0;
			col_e = '0;
		end else begin
			row_e = row_q;
			col_e = col_q;
		end
		w_m1    = POS_W'(cfg.width - 1'b1);
		h_m1    = POS_W'(cfg.height - 1'b1);
		last    = ({1'b0, row_e} == orows - 1'b1) && ({1'b0, col_e} == ocols - 1'b1);
		col_inc = {1'b0, col_e} + 1'b1;
	end

	// Source pixel position for the current output position.
	always_comb begin
		unique case (cfg.mode)
			MODE_MIRROR: begin
				sr = row_e;
				sc = w_m1 - col_e;
			end
			MODE_ROT_R: begin
				sr = h_m1 - col_e;
				sc = row_e;
			end
			MODE_ROT_L: begin
				sr = col_e;
				sc = w_m1 - row_e;
			end
			default: begin
				sr = row_e;
				sc = col_e;
			end
		endcase
	end

	// Load pointer and output counters.
	assign load_ok = lp_q < cfg.area;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= '0;
			row_q <= '0;
			col_q <= '0;
		end else begin
			if (cmd.load_write && load_ok) begin
				lp_q <= lp_q + 1'b1;
			end
			if (cmd.pos_step) begin
				if (last) begin
					lp_q  <= '0;
					row_q <= '0;
					col_q <= '0;
				end else if (col_inc >= ocols) begin
					col_q <= '0;
					row_q <= row_e + 1'b1;
				end else begin
					col_q <= col_inc[POS_W-1:0];
					row_q <= row_e;
				end
			end
		end
	end

	// Fetch pipeline payload: position, address product, store read.
	assign rd_addr = prod_s2 + {{(ADDR_W-POS_W){1'b0}}, sc_s2};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= pixel_in;
		end
		if (cmd.pos_step) begin
			sr_s1   <= sr;
			sc_s1   <= sc;
			last_s1 <= last;
		end
		if (cmd.mul_step) begin
			prod_s2 <= {{(ADDR_W-POS_W){1'b0}}, sr_s1} * {{(ADDR_W-DIM_W){1'b0}}, cfg.width};
			sc_s2   <= sc_s1;
		end
	end

	// Frame store: one write port for loads, one registered read port for fetches.
	always_ff @(posedge clk) begin
		if (cmd.load_write && load_ok) begin
			mem[lp_q[ADDR_W-1:0]] <= pix_q;
		end
		if (cmd.read_step) begin
			rdata_s3 <= mem[rd_addr];
		end
	end

	// Point operation on the read pixel.
	always_comb begin
		bright_sum = {1'b0, rdata_s3} + {1'b0, cfg.step_amount};
		unique case (cfg.mode)
			MODE_NEGATIVE: begin
				value = (cfg.max_level >= rdata_s3) ? cfg.max_level - rdata_s3 : '0;
			end
			MODE_DARKEN: begin
				value = (rdata_s3 > cfg.step_amount) ? rdata_s3 - cfg.step_amount : '0;
			end
			MODE_BRIGHTEN: begin
				value = bright_sum[PIX_W] ? {PIX_W{1'b1}} : bright_sum[PIX_W-1:0];
			end
			default: value = rdata_s3;
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pixel_out_q <= value;
			last_q      <= last_s1;
		end
	end

	assign pixel_out     = pixel_out_q;
	assign last_of_frame = last_q;

endmodule
